FILE: src/fourier_series_trajectory_eval_defines.svh
// assertion macros for the rtl
`ifndef FOURIER_SERIES_TRAJECTORY_EVAL_DEFINES_SVH
`define FOURIER_SERIES_TRAJECTORY_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
// check under reset qualification
`define FSTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that also holds while reset is applied
`define FSTE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSTE_ASSERT(lbl, prop, msg)
`define FSTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/fste_pkg.sv
package fste_pkg;

	localparam int ORDER  = 5;
	localparam int JOINTS = 8;
	localparam int WPJ    = 2 * ORDER + 1;
	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int SIDX_W = $clog2(WPJ);
	localparam int HW     = $clog2(ORDER + 1);

	localparam int JOINT_W = 3;
	localparam int SLOT_W  = 4;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 104;

	// register indexes
	localparam logic REG_WF  = 1'b0;
	localparam logic REG_INV = 1'b1;

	// item kinds
	localparam logic MODE_EVAL = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [30:0] WF_RESET  = 31'd65536;
	localparam logic [30:0] INV_RESET = 31'd65536;

	function automatic logic [16:0] quarter_sine(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0: v = 17'd0;
			5'd1: v = 17'd6424;
			5'd2: v = 17'd12785;
			5'd3: v = 17'd19024;
			5'd4: v = 17'd25080;
			5'd5: v = 17'd30893;
			5'd6: v = 17'd36410;
			5'd7: v = 17'd41576;
			5'd8: v = 17'd46341;
			5'd9: v = 17'd50660;
			5'd10: v = 17'd54491;
			5'd11: v = 17'd57798;
			5'd12: v = 17'd60547;
			5'd13: v = 17'd62714;
			5'd14: v = 17'd64277;
			5'd15: v = 17'd65220;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

	// quarter-wave sine with linear interpolation, argument 0..16384
	function automatic logic [16:0] qsin(input logic [14:0] x);
		logic [4:0]  i;
		logic [9:0]  f;
		logic [16:0] base;
		logic [16:0] d;
		logic [26:0] t;
		i    = x[14:10];
		f    = x[9:0];
		base = quarter_sine(i);
		d    = quarter_sine(5'(i + 5'd1)) - base;
		t    = 27'(d) * 27'(f) + 27'd512;
		if (i >= 5'd16) begin
			return 17'd65536;
		end
		return base + 17'(t[26:10]);
	endfunction

	function automatic logic signed [17:0] sine16(input logic [15:0] p);
		logic [13:0] r;
		logic [16:0] m;
		r = p[13:0];
		case (p[15:14])
			2'd0: m = qsin({1'b0, r});
			2'd1: m = qsin(15'(15'd16384 - {1'b0, r}));
			2'd2: m = qsin({1'b0, r});
			default: m = qsin(15'(15'd16384 - {1'b0, r}));
		endcase
		if (p[15]) begin
			return -$signed({1'b0, m});
		end
		return $signed({1'b0, m});
	endfunction

	// q16.16 product rescale, rounded half away from zero
	function automatic logic signed [63:0] qmul(input logic signed [65:0] p);
		logic [65:0] m;
		logic [65:0] r;
		m = p[65] ? 66'(-p) : 66'(p);
		r = (m + 66'd32768) >> 16;
		if (p[65]) begin
			return -$signed(r[63:0]);
		end
		return $signed(r[63:0]);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

FILE: src/fourier_series_trajectory_eval.sv
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: joint, slot, coef_value, phase; tuser: mode
// m_axis    | out | m_axis_tvalid/tready   | tdata: joint_out, position, velocity, acceleration
// cfg       | in  | cfg_we                 | cfg_index, cfg_wdata
//
// seven register stages from s_axis to m_axis; one transfer per cycle when nothing stalls
// a result is registered through stages 1 to 7 into m_axis; a load item leaves no result
// after reset the store reads as zero via per-word valid bits; items wait while m_axis stalls
// the per-harmonic reciprocals follow inv_q in the cycle after it is written
// a stall on m_axis freezes the whole pipeline; nothing is dropped or repeated
`include "fourier_series_trajectory_eval_defines.svh"

module fourier_series_trajectory_eval
	import fste_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] joint, [6:3] slot, [38:7] coef_value, [54:39] phase, [55] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	// [0] mode
	input  logic             s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [2:0] joint_out, [34:3] position, [66:35] velocity, [98:67] acceleration, [103:99] zero
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [30:0]      cfg_wdata
);

	// configuration
	logic [30:0] wf_q;
	logic [30:0] inv_q;
	logic [ORDER-1:0][30:0] inv_h_next;
	logic [ORDER-1:0][30:0] inv_h_q;

	// input unpack
	logic              adv;
	logic              in_xfer;
	logic [JOINT_W-1:0] in_joint;
	logic [SLOT_W-1:0]  in_slot;
	logic [31:0]        in_coef;
	logic [15:0]        in_phase;
	logic               in_range;

	// coefficient store valid bits
	logic [WPJ-1:0] vld_q [JOINTS];

	// stage 1
	logic              v_s1;
	logic              ok_s1;
	logic [JOINT_W-1:0] joint_s1;
	logic [15:0]       phase_s1;
	logic [WPJ-1:0][31:0] row_s1;
	logic [WPJ-1:0]    vmask_s1;

	// stage 2
	logic               v_s2;
	logic [JOINT_W-1:0] joint_s2;
	logic signed [31:0] a_s2 [ORDER];
	logic signed [31:0] b_s2 [ORDER];
	logic signed [31:0] off_s2;
	logic signed [17:0] sin_s2 [ORDER];
	logic signed [17:0] cos_s2 [ORDER];

	// stage 3
	logic               v_s3;
	logic [JOINT_W-1:0] joint_s3;
	logic signed [33:0] as_s3 [ORDER];
	logic signed [33:0] bc_s3 [ORDER];
	logic signed [34:0] vel_s3 [ORDER];
	logic signed [31:0] off_s3;

	// stage 4
	logic               v_s4;
	logic [JOINT_W-1:0] joint_s4;
	logic signed [49:0] pia_s4 [ORDER];
	logic signed [49:0] pib_s4 [ORDER];
	logic signed [49:0] pwa_s4 [ORDER];
	logic signed [49:0] pwb_s4 [ORDER];
	logic signed [34:0] vel_s4 [ORDER];
	logic signed [31:0] off_s4;

	// stage 5
	logic               v_s5;
	logic [JOINT_W-1:0] joint_s5;
	logic signed [50:0] pos_s5 [ORDER];
	logic signed [56:0] acc_s5 [ORDER];
	logic signed [34:0] vel_s5 [ORDER];
	logic signed [31:0] off_s5;

	// stage 6
	logic               v_s6;
	logic [JOINT_W-1:0] joint_s6;
	logic signed [63:0] pos_sum_s6;
	logic signed [63:0] vel_sum_s6;
	logic signed [63:0] acc_sum_s6;
	logic signed [63:0] pos_sum;
	logic signed [63:0] vel_sum;
	logic signed [63:0] acc_sum;

	// output register
	logic               v_s7;
	logic [OUT_W-1:0]   data_s7;

	assign in_joint = s_axis_tdata[2:0];
	assign in_slot  = s_axis_tdata[6:3];
	assign in_coef  = s_axis_tdata[38:7];
	assign in_phase = s_axis_tdata[54:39];
	assign in_range = ({1'b0, in_joint} < 4'(JOINTS));

	// whole pipeline moves together; the output register empties or is being taken
	assign adv           = !v_s7 || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q  <= WF_RESET;
			inv_q <= INV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WF: wf_q <= cfg_wdata;
				REG_INV: inv_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// inv_h = (inv + h/2) / h by reciprocal multiplication, exact for 32-bit numerators
	for (genvar l = 0; l < ORDER; l++) begin : g_recip
		localparam int SH = 32 + $clog2(l + 1);
		localparam logic [65:0] MAGIC = ((66'd1 << SH) + 66'(l)) / 66'(l + 1);
		logic [65:0] prod;
		assign prod          = (66'({1'b0, inv_q}) + 66'((l + 1) / 2)) * MAGIC;
		assign inv_h_next[l] = 31'(prod >> SH);
	end

	always_ff @(posedge clk) begin
		inv_h_q <= inv_h_next;
	end

	// coefficient store: valid bits stand in for the all-zero reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOINTS; j++) begin
				vld_q[j] <= '0;
			end
		end else if (in_xfer && s_axis_tuser == MODE_LOAD && in_range
				&& in_slot < SLOT_W'(WPJ)) begin
			vld_q[in_joint[JIDX_W-1:0]][in_slot[SIDX_W-1:0]] <= 1'b1;
		end
	end

	// one bank per slot, each read at the item's joint
	for (genvar s = 0; s < WPJ; s++) begin : g_bank
		logic [31:0] bank [JOINTS];
		logic [31:0] rd_s1;
		always_ff @(posedge clk) begin
			if (in_xfer && s_axis_tuser == MODE_LOAD && in_range && in_slot == SLOT_W'(s)) begin
				bank[in_joint[JIDX_W-1:0]] <= in_coef;
			end
			if (adv) begin
				rd_s1 <= bank[in_joint[JIDX_W-1:0]];
			end
		end
		assign row_s1[s] = rd_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vmask_s1 <= vld_q[in_joint[JIDX_W-1:0]];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_xfer && s_axis_tuser == MODE_EVAL;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// final sums of all harmonic lanes
	always_comb begin
		pos_sum = 64'(off_s5);
		vel_sum = '0;
		acc_sum = '0;
		for (int l = 0; l < ORDER; l++) begin
			pos_sum = pos_sum + 64'(pos_s5[l]);
			vel_sum = vel_sum + 64'(vel_s5[l]);
			acc_sum = acc_sum + 64'(acc_s5[l]);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: item fields beside the store row
			ok_s1    <= in_range;
			joint_s1 <= in_joint;
			phase_s1 <= in_phase;

			// stage 2: coefficients, sine and cosine of each harmonic
			joint_s2 <= joint_s1;
			off_s2   <= (ok_s1 && vmask_s1[2*ORDER]) ? $signed(row_s1[2*ORDER]) : '0;
			for (int l = 0; l < ORDER; l++) begin
				a_s2[l]   <= (ok_s1 && vmask_s1[l]) ? $signed(row_s1[l]) : '0;
				b_s2[l]   <= (ok_s1 && vmask_s1[ORDER+l]) ? $signed(row_s1[ORDER+l]) : '0;
				sin_s2[l] <= sine16(16'(phase_s1 * 16'(l + 1)));
				cos_s2[l] <= sine16(16'(phase_s1 * 16'(l + 1)) + 16'd16384);
			end

			// stage 3: amplitude times sine and cosine
			joint_s3 <= joint_s2;
			off_s3   <= off_s2;
			for (int l = 0; l < ORDER; l++) begin
				as_s3[l]  <= 34'(qmul(66'(a_s2[l] * sin_s2[l])));
				bc_s3[l]  <= 34'(qmul(66'(b_s2[l] * cos_s2[l])));
				vel_s3[l] <= 35'(qmul(66'(a_s2[l] * cos_s2[l])))
					+ 35'(qmul(66'(b_s2[l] * sin_s2[l])));
			end

			// stage 4: scale by 1/(h*wf) and by wf
			joint_s4 <= joint_s3;
			off_s4   <= off_s3;
			for (int l = 0; l < ORDER; l++) begin
				pia_s4[l] <= 50'(qmul(66'(as_s3[l] * $signed({1'b0, inv_h_q[l]}))));
				pib_s4[l] <= 50'(qmul(66'(bc_s3[l] * $signed({1'b0, inv_h_q[l]}))));
				pwa_s4[l] <= 50'(qmul(66'(as_s3[l] * $signed({1'b0, wf_q}))));
				pwb_s4[l] <= 50'(qmul(66'(bc_s3[l] * $signed({1'b0, wf_q}))));
				vel_s4[l] <= vel_s3[l];
			end

			// stage 5: lane terms, acceleration times harmonic number
			joint_s5 <= joint_s4;
			off_s5   <= off_s4;
			for (int l = 0; l < ORDER; l++) begin
				pos_s5[l] <= 51'(pia_s4[l]) - 51'(pib_s4[l]);
				acc_s5[l] <= 57'((51'(pwb_s4[l]) - 51'(pwa_s4[l])) * $signed(7'(l + 1)));
				vel_s5[l] <= vel_s4[l];
			end

			// stage 6: totals
			joint_s6   <= joint_s5;
			pos_sum_s6 <= pos_sum;
			vel_sum_s6 <= vel_sum;
			acc_sum_s6 <= acc_sum;

			// stage 7: saturate into the output register
			data_s7 <= {5'd0, sat32(acc_sum_s6), sat32(vel_sum_s6), sat32(pos_sum_s6), joint_s6};
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = data_s7;

	// a load never starts a result
	`FSTE_ASSERT(a_load_no_result, (in_xfer && s_axis_tuser == MODE_LOAD && adv) |=> !v_s1, "load item produced a result")
	// a waiting result holds its data
	`FSTE_ASSERT(a_out_stable, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while waiting")
	// the first harmonic reciprocal is the register itself
	`FSTE_ASSERT(a_inv_first, $stable(inv_q) |-> (inv_h_q[0] == inv_q), "first reciprocal wrong")
	// no item accepted while a result waits
	`FSTE_ASSERT_ALWAYS(a_stall_blocks, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "item taken during stall")

endmodule

FILE: verif/fourier_series_trajectory_eval_checker.sv
`timescale 1ns / 100ps

module fourier_series_trajectory_eval_checker
	import fste_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             s_axis_tuser,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [30:0]      cfg_wdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [2:0]  joint;
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
	} setpoint_t;

	localparam logic [16:0] QTAB [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410,
		41576, 46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

	logic [31:0] coefs [JOINTS][WPJ];
	logic [30:0] wf_reg;
	logic [30:0] inv_reg;
	setpoint_t   setpoint_q [$];

	function automatic longint quarter_wave(input int x);
		int i;
		int f;
		i = x >> 10;
		f = x & 'h3ff;
		if (i >= 16) begin
			return 65536;
		end
		return QTAB[i] + (((QTAB[i+1] - QTAB[i]) * f + 512) >> 10);
	endfunction

	function automatic longint wave_sine(input int p);
		int r;
		r = p & 'h3fff;
		case ((p >> 14) & 3)
			0: return quarter_wave(r);
			1: return quarter_wave(16384 - r);
			2: return -quarter_wave(r);
			default: return -quarter_wave(16384 - r);
		endcase
	endfunction

	function automatic longint fix_mul(input longint x, input longint y);
		longint p;
		p = x * y;
		if (p < 0) begin
			return -((-p + 32768) >>> 16);
		end
		return (p + 32768) >>> 16;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic setpoint_t eval_setpoint(input logic [2:0] j, input logic [15:0] ph);
		setpoint_t sp;
		longint pos, vel, acc, s, c, a, b, inv, as_, bc;
		int p;
		pos = 0;
		vel = 0;
		acc = 0;
		if (j < JOINTS) begin
			pos = longint'($signed(coefs[j][2*ORDER]));
			for (int h = 1; h <= ORDER; h++) begin
				p   = (h * ph) & 'hffff;
				s   = wave_sine(p);
				c   = wave_sine((p + 16384) & 'hffff);
				a   = longint'($signed(coefs[j][h-1]));
				b   = longint'($signed(coefs[j][ORDER+h-1]));
				inv = (longint'(inv_reg) + h / 2) / h;
				as_ = fix_mul(a, s);
				bc  = fix_mul(b, c);
				pos += fix_mul(as_, inv) - fix_mul(bc, inv);
				vel += fix_mul(a, c) + fix_mul(b, s);
				acc += (fix_mul(bc, longint'(wf_reg)) - fix_mul(as_, longint'(wf_reg))) * h;
			end
		end
		sp.joint = j;
		sp.pos   = clip32(pos);
		sp.vel   = clip32(vel);
		sp.acc   = clip32(acc);
		return sp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		setpoint_t got;
		setpoint_t want;
		logic [2:0] j;
		logic [3:0] sl;
		if (!arst_n) begin
			foreach (coefs[i, k]) coefs[i][k] = '0;
			wf_reg     = WF_RESET;
			inv_reg    = INV_RESET;
			fail_count = 0;
			pending    = 0;
			setpoint_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WF) wf_reg = cfg_wdata;
				else inv_reg = cfg_wdata;
			end
			// input transfer: loads update the store, evaluates queue a setpoint
			if (s_axis_tvalid && s_axis_tready) begin
				j  = s_axis_tdata[2:0];
				sl = s_axis_tdata[6:3];
				if (s_axis_tuser == MODE_LOAD) begin
					if (j < JOINTS && sl < WPJ) coefs[j][sl] = s_axis_tdata[38:7];
				end else begin
					setpoint_q.push_back(eval_setpoint(j, s_axis_tdata[54:39]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35],
					m_axis_tdata[98:67]};
				if (setpoint_q.size() == 0) begin
					$error("unexpected result transfer %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = setpoint_q.pop_front();
					if (got.joint !== want.joint) begin
						$error("joint_out: expected %0d, actual %0d", want.joint, got.joint);
						fail_count++;
					end
					if (got.pos !== want.pos) begin
						$error("position: expected %h, actual %h", want.pos, got.pos);
						fail_count++;
					end
					if (got.vel !== want.vel) begin
						$error("velocity: expected %h, actual %h", want.vel, got.vel);
						fail_count++;
					end
					if (got.acc !== want.acc) begin
						$error("acceleration: expected %h, actual %h", want.acc, got.acc);
						fail_count++;
					end
				end
			end
			pending = setpoint_q.size();
		end
	end

endmodule

FILE: verif/fourier_series_trajectory_eval_tb.sv
`timescale 1ns / 100ps

module fourier_series_trajectory_eval_tb;
	import fste_pkg::*;

	// idle cycles with nothing accepted before the run is declared hung;
	// covers the longest gaps, stalls and register writes by a wide margin
	localparam int HANG_LIMIT = 5000;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we;
	logic             cfg_index;
	logic [30:0]      cfg_wdata;
	int               fail_count;
	int               pending;
	int               idle_cycles;
	int               items_sent;
	bit               burst_mode;

	fourier_series_trajectory_eval i_dut (.*);

	fourier_series_trajectory_eval_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= HANG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stall per result transfer, none in burst phases
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 13);
			repeat (stall) @(posedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			if (burst_mode) begin
				continue;
			end
			m_axis_tready <= 1'b0;
		end
	end

	// one input transfer; gap drawn before it, valid held until accepted
	task automatic send_item(input logic mode, input logic [2:0] j, input logic [3:0] sl,
		input logic [31:0] coef, input logic [15:0] ph);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {1'b0, ph, coef, sl, j};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	// wait out all results, then the pipeline depth, then write one register
	task automatic write_reg(input logic idx, input logic [30:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 'h3ffff)) - 'sh20000);
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 'h3ffffff)) - 'sh2000000);
		endcase
	endfunction

	// fill a joint fully, then evaluate it at several phases
	task automatic random_run();
		logic [2:0] j;
		j = $urandom_range(0, 7);
		for (int k = 0; k < WPJ; k++) begin
			send_item(MODE_LOAD, j, 4'(k), rand_coef(), 16'($urandom()));
		end
		repeat ($urandom_range(1, 6)) begin
			send_item(MODE_EVAL, j, 4'($urandom()), $urandom(), 16'($urandom()));
		end
		// noise: stray loads, out-of-range slots, evaluates of other joints
		repeat ($urandom_range(0, 3)) begin
			send_item($urandom_range(0, 1) ? MODE_LOAD : MODE_EVAL, 3'($urandom()),
				4'($urandom()), rand_coef(), 16'($urandom()));
		end
	endtask

	logic [30:0] wf_set   [4] = '{31'd1, 31'h7fff_ffff, 31'd411775, 31'd0};
	logic [30:0] inv_set  [4] = '{31'h7fff_ffff, 31'd1, 31'd10430, 31'd0};

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_EVAL;
		cfg_we        = 1'b0;
		cfg_index     = REG_WF;
		cfg_wdata     = '0;
		idle_cycles   = 0;
		items_sent    = 0;
		burst_mode    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset store, extremes, ignored slot and max-phase evaluates
		send_item(MODE_EVAL, 3'd0, 4'd0, 32'h0, 16'h0000);
		send_item(MODE_LOAD, 3'd1, 4'd0, 32'h7fff_ffff, 16'hffff);
		send_item(MODE_LOAD, 3'd1, 4'd5, 32'h8000_0000, 16'h0);
		send_item(MODE_LOAD, 3'd1, 4'd10, 32'h8000_0000, 16'h0);
		send_item(MODE_LOAD, 3'd1, 4'd11, 32'h1234_5678, 16'h0);  // slot past offset
		send_item(MODE_LOAD, 3'd1, 4'd15, 32'hffff_ffff, 16'h0);
		send_item(MODE_EVAL, 3'd1, 4'd15, 32'hffff_ffff, 16'h0000);
		send_item(MODE_EVAL, 3'd1, 4'd0, 32'h0, 16'h4000);
		send_item(MODE_EVAL, 3'd1, 4'd0, 32'h0, 16'h8000);
		send_item(MODE_EVAL, 3'd1, 4'd0, 32'h0, 16'hc000);
		send_item(MODE_EVAL, 3'd1, 4'd0, 32'h0, 16'hffff);
		for (int k = 0; k < WPJ; k++) begin
			send_item(MODE_LOAD, 3'd7, 4'(k), 32'h8000_0000, 16'h0);
		end
		send_item(MODE_EVAL, 3'd7, 4'd0, 32'h0, 16'h1555);
		send_item(MODE_EVAL, 3'd7, 4'd0, 32'h0, 16'h0001);

		// random phases, one per register setting, extremes and zero included
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_reg(REG_WF, wf_set[ph-1]);
				write_reg(REG_INV, inv_set[ph-1]);
			end
			burst_mode = (ph == 2);
			while (items_sent < 170 * (ph + 1)) begin
				random_run();
			end
		end
		burst_mode = 1'b0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
